/* rtl/core/wbp_pkg.sv */
// Shared types and constants for the write batch record parser.
package wbp_pkg;

    localparam int MAX_PARTITIONS = 16;
    localparam int HEADER_BYTES   = 12;
    localparam int RES_SLOTS      = 3;

    // partition bound is never above 16, whatever MAX_PARTITIONS says
    localparam logic [4:0] PART_CAP = 5'((MAX_PARTITIONS < 16) ? MAX_PARTITIONS : 16);

    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_RECORD = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL     = 3'd1;
    localparam logic [2:0] ST_BAD_PUT       = 3'd2;
    localparam logic [2:0] ST_BAD_DELETE    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN_TAG   = 3'd4;
    localparam logic [2:0] ST_WRONG_COUNT   = 3'd5;
    localparam logic [2:0] ST_BAD_PARTITION = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        plast;
        logic        op_put;
        logic [3:0]  part;
        logic [63:0] seq;
        logic [2:0]  status;
        logic        last;
    } t_result;

endpackage

/* rtl/core/wbp_parse.sv */
// Parser state and per-word decode: one batch word in, up to three results out.
module wbp_parse (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_fire,
    input  logic [7:0]                                  i_byte,
    input  logic                                        i_end,
    input  logic [4:0]                                  i_part_cnt,
    output wbp_pkg::t_result [wbp_pkg::RES_SLOTS-1:0]   o_res,
    output logic [1:0]                                  o_res_cnt
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_TAG    = 3'd1;
    localparam logic [2:0] PH_KLEN   = 3'd2;
    localparam logic [2:0] PH_KEY    = 3'd3;
    localparam logic [2:0] PH_VLEN   = 3'd4;
    localparam logic [2:0] PH_VAL    = 3'd5;
    localparam logic [2:0] PH_ERROR  = 3'd6;

    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_hdr_idx, n_hdr_idx;
    logic [63:0] r_seq, n_seq;
    logic [31:0] r_decl, n_decl;
    logic [31:0] r_found, n_found;
    logic [31:0] r_vacc, n_vacc;
    logic [2:0]  r_vbytes, n_vbytes;
    logic [31:0] r_left, n_left;
    logic        r_put, n_put;
    logic [2:0]  r_kidx, n_kidx;
    logic [7:0]  r_route, n_route;
    logic        r_seen, n_seen;
    logic [2:0]  r_err, n_err;

    logic [31:0] v_sh;
    logic        v_fin;
    logic        v_pay;
    logic        v_rec;
    logic [4:0]  v_bound;
    logic [7:0]  v_idx;
    logic [2:0]  v_st;
    wbp_pkg::t_result c_pay, c_rec, c_stat;

    always_comb begin
        n_phase  = r_phase;
        n_hdr_idx = r_hdr_idx;
        n_seq    = r_seq;
        n_decl   = r_decl;
        n_found  = r_found;
        n_vacc   = r_vacc;
        n_vbytes = r_vbytes;
        n_left   = r_left;
        n_put    = r_put;
        n_kidx   = r_kidx;
        n_route  = r_route;
        n_seen   = r_seen;
        n_err    = r_err;
        v_fin    = 1'b0;
        v_pay    = 1'b0;
        v_rec    = 1'b0;
        v_idx    = 8'd0;
        v_st     = wbp_pkg::ST_OK;
        // bits shifted above bit 31 fall off
        v_sh     = {25'd0, i_byte[6:0]} << ({2'b00, r_vbytes} * 5'd7);
        v_bound  = (i_part_cnt > wbp_pkg::PART_CAP) ? wbp_pkg::PART_CAP : i_part_cnt;
        c_pay    = '0;
        c_rec    = '0;
        c_stat   = '0;

        case (r_phase)
            PH_HEADER: begin
                if (r_hdr_idx < 4'd8) begin
                    n_seq[{r_hdr_idx[2:0], 3'b000} +: 8] =
                        r_seq[{r_hdr_idx[2:0], 3'b000} +: 8] | i_byte;
                end else if (r_hdr_idx < 4'(wbp_pkg::HEADER_BYTES)) begin
                    n_decl[{r_hdr_idx[1:0], 3'b000} +: 8] =
                        r_decl[{r_hdr_idx[1:0], 3'b000} +: 8] | i_byte;
                end
                n_hdr_idx = r_hdr_idx + 4'd1;
                if (n_hdr_idx >= 4'(wbp_pkg::HEADER_BYTES)) begin
                    n_phase = PH_TAG;
                end
            end
            PH_TAG: begin
                n_found = r_found + 32'd1;
                if (i_byte[7:1] == 7'd0) begin
                    n_put    = i_byte[0];
                    n_kidx   = 3'd0;
                    n_seen   = 1'b0;
                    n_route  = 8'd0;
                    n_vacc   = 32'd0;
                    n_vbytes = 3'd0;
                    n_phase  = PH_KLEN;
                end else begin
                    n_err   = wbp_pkg::ST_UNKNOWN_TAG;
                    n_phase = PH_ERROR;
                end
            end
            PH_KLEN, PH_VLEN: begin
                n_vacc = r_vacc | v_sh;
                if (i_byte[7]) begin
                    if (r_vbytes >= 3'd4) begin
                        n_err   = r_put ? wbp_pkg::ST_BAD_PUT : wbp_pkg::ST_BAD_DELETE;
                        n_phase = PH_ERROR;
                    end else begin
                        n_vbytes = r_vbytes + 3'd1;
                    end
                end else begin
                    n_left = n_vacc;
                    if (r_phase == PH_KLEN) begin
                        if (n_vacc != 32'd0) begin
                            n_phase = PH_KEY;
                        end else if (r_put) begin
                            n_vacc   = 32'd0;
                            n_vbytes = 3'd0;
                            n_phase  = PH_VLEN;
                        end else begin
                            v_fin = 1'b1;
                        end
                    end else begin
                        if (n_vacc != 32'd0) n_phase = PH_VAL;
                        else v_fin = 1'b1;
                    end
                end
            end
            PH_KEY: begin
                if (r_kidx == 3'd4) begin
                    n_route = i_byte;
                    n_seen  = 1'b1;
                end
                if (r_kidx < 3'd5) n_kidx = r_kidx + 3'd1;
                n_left = r_left - 32'd1;
                v_pay  = 1'b1;
                c_pay.kind  = wbp_pkg::KIND_KEY;
                c_pay.data  = i_byte;
                c_pay.plast = (n_left == 32'd0);
                if (n_left == 32'd0) begin
                    if (r_put) begin
                        n_vacc   = 32'd0;
                        n_vbytes = 3'd0;
                        n_phase  = PH_VLEN;
                    end else begin
                        v_fin = 1'b1;
                    end
                end
            end
            PH_VAL: begin
                n_left = r_left - 32'd1;
                v_pay  = 1'b1;
                c_pay.kind  = wbp_pkg::KIND_VALUE;
                c_pay.data  = i_byte;
                c_pay.plast = (n_left == 32'd0);
                if (n_left == 32'd0) v_fin = 1'b1;
            end
            default: begin
            end
        endcase

        // record close: route from key byte 4, checked against the bound
        if (v_fin) begin
            v_idx = n_route - 8'h31;
            if (!n_seen || n_route < 8'h31 || v_idx >= {3'b000, v_bound}) begin
                n_err   = wbp_pkg::ST_BAD_PARTITION;
                n_phase = PH_ERROR;
            end else begin
                v_rec = 1'b1;
                c_rec.kind   = wbp_pkg::KIND_RECORD;
                c_rec.op_put = n_put;
                c_rec.part   = v_idx[3:0];
                c_rec.seq    = r_seq;
                n_seq   = r_seq + 64'd1;
                n_phase = PH_TAG;
            end
        end

        if (n_phase == PH_ERROR)       v_st = n_err;
        else if (n_phase == PH_HEADER) v_st = wbp_pkg::ST_TOO_SMALL;
        else if (n_phase != PH_TAG)
            v_st = n_put ? wbp_pkg::ST_BAD_PUT : wbp_pkg::ST_BAD_DELETE;
        else if (n_found == n_decl)    v_st = wbp_pkg::ST_OK;
        else                           v_st = wbp_pkg::ST_WRONG_COUNT;
        c_stat.kind   = wbp_pkg::KIND_STATUS;
        c_stat.status = v_st;
        c_stat.last   = 1'b1;
        c_rec.last    = !i_end;
        c_pay.last    = !v_rec && !i_end;

        if (i_end) begin
            n_phase   = PH_HEADER;
            n_hdr_idx = 4'd0;
            n_seq     = 64'd0;
            n_decl    = 32'd0;
            n_found   = 32'd0;
            n_vacc    = 32'd0;
            n_vbytes  = 3'd0;
            n_left    = 32'd0;
            n_put     = 1'b0;
            n_kidx    = 3'd0;
            n_route   = 8'd0;
            n_seen    = 1'b0;
            n_err     = wbp_pkg::ST_OK;
        end

        // pack present results into the low slots in order
        o_res[0] = v_pay ? c_pay : (v_rec ? c_rec : c_stat);
        o_res[1] = (v_pay && v_rec) ? c_rec : c_stat;
        o_res[2] = c_stat;
        o_res_cnt = 2'({1'b0, v_pay} + {1'b0, v_rec} + {1'b0, i_end});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_idx <= 4'd0;
            r_seq     <= 64'd0;
            r_decl    <= 32'd0;
            r_found   <= 32'd0;
            r_vacc    <= 32'd0;
            r_vbytes  <= 3'd0;
            r_left    <= 32'd0;
            r_put     <= 1'b0;
            r_kidx    <= 3'd0;
            r_route   <= 8'd0;
            r_seen    <= 1'b0;
            r_err     <= wbp_pkg::ST_OK;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_seq     <= n_seq;
            r_decl    <= n_decl;
            r_found   <= n_found;
            r_vacc    <= n_vacc;
            r_vbytes  <= n_vbytes;
            r_left    <= n_left;
            r_put     <= n_put;
            r_kidx    <= n_kidx;
            r_route   <= n_route;
            r_seen    <= n_seen;
            r_err     <= n_err;
        end
    end

endmodule

/* rtl/core/write_batch_record_parser.sv */
// Top level of the write batch record parser: input stage, parser and result buffer.
//
// Usage: batch bytes arrive one word per handshake on i_valid/o_ready with
// i_in_byte and i_batch_end (set on the final byte of a batch). Results leave
// one word per handshake on o_valid/i_ready: key bytes, value bytes, a
// record-done word per good record and a status word closing each batch;
// o_out_last marks the final result caused by one input byte.
// i_cfg_we/i_cfg_data load the partition count (reset value 1); write it only
// while the block is idle.
// Path: an accepted byte waits in the input register, and its results reach
// the output when the result buffer loads from that register.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver takes every word; a byte giving more results holds the input stage
// until the three-slot buffer, draining one word per ready cycle, empties.
// Reset (synchronous, active low) empties both stages and returns the parser
// to the header of a new batch. When the receiver stalls, the current result
// holds; the input stage takes one more byte and then drops o_ready.
module write_batch_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_batch_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_payload_last,
    output logic        o_op_put,
    output logic [3:0]  o_partition,
    output logic [63:0] o_seq_out,
    output logic [2:0]  o_status,
    output logic        o_out_last,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data
);

    logic [4:0] r_part_cnt;
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    wbp_pkg::t_result [wbp_pkg::RES_SLOTS-1:0] r_slot;
    wbp_pkg::t_result [wbp_pkg::RES_SLOTS-1:0] n_slot;
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] r_idx;

    logic take;
    logic buf_free;
    logic proc;
    wbp_pkg::t_result cur;

    assign take     = o_valid && i_ready;
    assign buf_free = (r_cnt == 2'd0) || (take && r_idx == r_cnt - 2'd1);
    assign proc     = r_in_vld && buf_free;
    assign o_ready  = !r_in_vld || proc;
    assign o_valid  = (r_cnt != 2'd0);

    wbp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (proc),
        .i_byte     (r_in_byte),
        .i_end      (r_in_end),
        .i_part_cnt (r_part_cnt),
        .o_res      (n_slot),
        .o_res_cnt  (n_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_cnt <= 5'd1;
        end else if (i_cfg_we) begin
            r_part_cnt <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_in_byte;
            r_in_end  <= i_batch_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (proc) begin
            r_cnt <= n_cnt;
            r_idx <= 2'd0;
        end else if (take) begin
            if (r_idx == r_cnt - 2'd1) r_cnt <= 2'd0;
            else r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_slot <= n_slot;
        end
    end

    always_comb begin
        case (r_idx)
            2'd0:    cur = r_slot[0];
            2'd1:    cur = r_slot[1];
            default: cur = r_slot[2];
        endcase
    end

    assign o_out_kind     = cur.kind;
    assign o_out_byte     = cur.data;
    assign o_payload_last = cur.plast;
    assign o_op_put       = cur.op_put;
    assign o_partition    = cur.part;
    assign o_seq_out      = cur.seq;
    assign o_status       = cur.status;
    assign o_out_last     = cur.last;

    // read pointer stays inside the filled part of the buffer
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_idx < r_cnt)
        else $error("result read pointer beyond fill");

    // last flag sits exactly on the final buffered word
    a_last_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_last == (r_idx == r_cnt - 2'd1)))
        else $error("out_last does not match buffer end");

    // a status word always closes the results of its byte
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_kind == wbp_pkg::KIND_STATUS) |-> o_out_last)
        else $error("status word not last");

    // input stage holds a word whenever it refuses new ones
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_vld && o_valid && !(i_ready && o_out_last)))
        else $error("input stalled without cause");

endmodule
